// ===== sv/sha256_pkg.sv =====
// Package: SHA-256 constants, round functions and shared types.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int unsigned NumRounds = 64;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD2  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_LEN   = 6'b100000
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] a);
        big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] e);
        big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] w);
        sml_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] w);
        sml_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
    endfunction

endpackage

// ===== sv/sha256_message_hasher_top.sv =====
// Top level: byte-serial SHA-256 hasher with one shared round unit.
//
// Each word carries at most one message byte; a word with end_of_message closes the
// message. A word that neither fills a block nor closes the message leaves the input
// open, so such words can follow back to back. The 64th byte of a block holds the
// input off (o_stall high) while the single round unit runs 64 rounds, one per cycle,
// and then folds the result into the chaining words. No byte is taken while a block
// is compressed, so the round loop limits the byte rate. A final word pads and runs
// one or two block passes of 64 rounds and the fold each; a second pass first loads
// the length block. The eight digest words then appear on the output register, one
// per accepted output word. The input stays stalled until the eighth word is taken.
`timescale 1ns / 1ps
module sha256_message_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state r_state, n_state;

    logic [31:0] r_chain [8];
    logic [31:0] r_wv    [8];   // working variables a..h
    logic [31:0] r_w     [16];  // message schedule window, block buffer at start
    logic [60:0] r_count;
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic        r_final;       // message closing: padding is in progress
    logic        r_two;         // length goes in a second block
    logic        r_lead;        // second block opens with the pad byte
    logic [2:0]  r_oidx;

    logic        acc;
    logic [31:0] t1, t2, w_new, w_cur;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != sha256_pkg::ST_IDLE);
    assign o_valid = (r_state == sha256_pkg::ST_OUT);
    assign o_word_index = r_oidx;
    assign o_last_word = (r_oidx == 3'd7);
    assign o_digest_word = r_chain[r_oidx];

    // Shared round unit
    assign w_cur = r_w[0];
    assign t1 = r_wv[7] + sha256_pkg::big_s1(r_wv[4])
              + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
              + sha256_pkg::ROUND_K[r_round] + w_cur;
    assign t2 = sha256_pkg::big_s0(r_wv[0])
              + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
    assign w_new = sha256_pkg::sml_s1(r_w[14]) + r_w[9] + sha256_pkg::sml_s0(r_w[1]) + r_w[0];

    // Byte write into the block buffer, big-endian
    function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = old;
        unique case (pos)
            2'd0:    r = {b, 24'd0};
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8] = b;
            default: r[7:0] = b;
        endcase
        return r;
    endfunction

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE:  begin
                if (acc) begin
                    if (i_has_byte && r_fill == 6'd63) n_state = sha256_pkg::ST_ROUND;
                    else if (i_end_of_message) n_state = sha256_pkg::ST_PAD2;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_round == 6'(sha256_pkg::NumRounds - 1)) n_state = sha256_pkg::ST_FOLD;
            end
            sha256_pkg::ST_FOLD:  begin
                if (!r_final) n_state = sha256_pkg::ST_IDLE;
                else if (r_two) n_state = sha256_pkg::ST_LEN;
                else n_state = sha256_pkg::ST_OUT;
            end
            sha256_pkg::ST_PAD2:  n_state = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_LEN:   n_state = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_OUT:   if (!i_stall && r_oidx == 3'd7) n_state = sha256_pkg::ST_IDLE;
            default:              n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and control counters
    always_ff @(posedge i_clk) begin
        logic [5:0]  fp;
        logic [3:0]  wi;
        logic [63:0] bits;
        logic [31:0] blk [16];
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= sha256_pkg::H_INIT[i];
            r_count <= '0;
            r_fill  <= '0;
            r_round <= '0;
            r_final <= 1'b0;
            r_two   <= 1'b0;
            r_lead  <= 1'b0;
            r_oidx  <= '0;
        end else begin
            unique case (r_state)
                sha256_pkg::ST_IDLE: begin
                    if (acc) begin
                        fp = r_fill;
                        for (int i = 0; i < 16; i++) blk[i] = r_w[i];
                        if (i_has_byte) begin
                            blk[fp[5:2]] = put_byte(blk[fp[5:2]], fp[1:0], i_data_byte);
                            r_count <= r_count + 61'd1;
                            r_fill <= fp + 6'd1;
                            fp = fp + 6'd1;
                        end
                        r_final <= i_end_of_message;
                        r_round <= '0;
                        for (int i = 0; i < 8; i++) r_wv[i] <= r_chain[i];
                        // Block full by this byte: compress, padding block follows if final
                        if (i_has_byte && r_fill == 6'd63) begin
                            r_two  <= i_end_of_message;
                            r_lead <= i_end_of_message;
                        end else if (i_end_of_message) begin
                            wi = fp[5:2];
                            blk[wi] = put_byte(blk[wi], fp[1:0], sha256_pkg::PAD_BYTE);
                            for (int i = 0; i < 16; i++)
                                if (4'(i) > wi) blk[i] = '0;
                            r_two  <= (fp >= 6'd56);
                            r_lead <= 1'b0;
                            bits = {r_count + 61'(i_has_byte), 3'd0};
                            if (fp < 6'd56) begin
                                blk[14] = bits[63:32];
                                blk[15] = bits[31:0];
                            end
                        end
                        for (int i = 0; i < 16; i++) r_w[i] <= blk[i];
                    end
                end
                sha256_pkg::ST_ROUND: begin
                    r_wv[7] <= r_wv[6]; r_wv[6] <= r_wv[5]; r_wv[5] <= r_wv[4];
                    r_wv[4] <= r_wv[3] + t1;
                    r_wv[3] <= r_wv[2]; r_wv[2] <= r_wv[1]; r_wv[1] <= r_wv[0];
                    r_wv[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                    r_round <= r_round + 6'd1;
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_wv[i];
                        r_wv[i] <= r_chain[i] + r_wv[i];
                    end
                    r_fill <= '0;
                    r_round <= '0;
                    r_oidx <= '0;
                end
                sha256_pkg::ST_PAD2: begin
                    // wait state: block buffer loaded, working vars already set
                    r_round <= '0;
                end
                sha256_pkg::ST_LEN: begin
                    bits = {r_count, 3'd0};
                    r_w[0] <= r_lead ? {sha256_pkg::PAD_BYTE, 24'd0} : 32'd0;
                    for (int i = 1; i < 14; i++) r_w[i] <= '0;
                    r_w[14] <= bits[63:32];
                    r_w[15] <= bits[31:0];
                    r_two <= 1'b0;
                    r_lead <= 1'b0;
                end
                sha256_pkg::ST_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_chain[i] <= sha256_pkg::H_INIT[i];
                            r_count <= '0;
                            r_fill <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/sha256_checker.sv =====
// Checker: port-level properties of the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // Held output word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("output word changed while stalled");

    // last flag marks word seven only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last flag wrong");

    // Words come in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word
            |=> o_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest word order broken");

    // No input taken while digest is shown
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during output");

endmodule

bind sha256_message_hasher_top sha256_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_digest_word(o_digest_word),
    .o_word_index(o_word_index), .o_last_word(o_last_word)
);

// ===== tb/sv/tb_sha256_message_hasher_top.sv =====
// Testbench: byte-serial SHA-256 hasher checked against an in-bench hash predictor.
`timescale 1ns / 1ps
module tb_sha256_message_hasher_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha256_message_hasher_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_has_byte(i_has_byte),
        .i_end_of_message(i_end_of_message), .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Predictor state
    logic [31:0] hash_state [8];
    logic [31:0] msg_block [16];
    logic [60:0] msg_bytes;
    logic [6:0]  fill_pos;

    t_digest_word digest_queue [$];
    int          mismatches = 0;
    longint      cycle_count = 0;
    int          idle_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << ((32 - n) % 32));
    endfunction

    // One compression over msg_block into hash_state
    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + sha256_pkg::ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic place_byte(input logic [7:0] v);
        int idx;
        idx = fill_pos[5:2];
        if (fill_pos[1:0] == 2'd0) msg_block[idx] = {v, 24'h0};
        else msg_block[idx] |= 32'(v) << ((3 - fill_pos[1:0]) * 8);
    endtask

    task automatic hasher_reset();
        for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::H_INIT[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        msg_bytes = '0;
        fill_pos = '0;
    endtask

    // Advance the predictor by one accepted word
    task automatic predict_digest(input logic [7:0] v, input logic hb, input logic eom);
        logic [63:0] bits;
        t_digest_word dw;
        if (hb) begin
            place_byte(v);
            msg_bytes = msg_bytes + 61'd1;
            fill_pos++;
            if (fill_pos >= 64) begin
                compress();
                fill_pos = 0;
            end
        end
        if (eom) begin
            place_byte(sha256_pkg::PAD_BYTE);
            for (int i = fill_pos[5:2] + 1; i < 16; i++) msg_block[i] = '0;
            if (fill_pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) msg_block[i] = '0;
            end
            bits = {msg_bytes, 3'b000};
            msg_block[14] = bits[63:32];
            msg_block[15] = bits[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_state[i];
                dw.index = 3'(i);
                dw.last = (i == 7);
                digest_queue.push_back(dw);
            end
            for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::H_INIT[i];
            msg_bytes = '0;
            fill_pos = '0;
        end
    endtask

    // Send one word, with random idle cycles before it
    task automatic send_word(input logic [7:0] v, input logic hb, input logic eom);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= v;
        i_has_byte <= hb;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(v, hb, eom);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input int noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1)) begin
                send_word(8'($urandom), 1'b1, 1'b1);
                return;
            end
            send_word(8'($urandom), 1'b1, 1'b0);
        end
        send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Receiver stall: random, or held for a long stretch when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else i_stall <= ($urandom_range(99) < idle_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest word %h", o_digest_word);
            end else begin
                exp_w = digest_queue.pop_front();
                if (exp_w.word !== o_digest_word || exp_w.index !== o_word_index ||
                    exp_w.last !== o_last_word) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_w.word,
                                 exp_w.index, exp_w.last, o_digest_word, o_word_index,
                                 o_last_word);
                end
            end
        end
    end

    task automatic test_directed();
        send_word(8'h00, 1'b0, 1'b1);          // empty message
        send_word(8'hFF, 1'b0, 1'b0);          // ignored word
        send_word(8'hFF, 1'b1, 1'b1);          // single byte carried on final word
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'hAA, 1'b0, 1'b1);
        drain();
    endtask

    // Block boundaries: 55 and 64 bytes closed by an empty final word, 56 and 64
    // bytes with the final mark on the last byte; all-zero and all-ones content
    task automatic test_boundaries();
        int lens [4] = '{55, 56, 64, 64};
        foreach (lens[k]) begin
            for (int i = 0; i < lens[k]; i++)
                send_word(k[0] ? 8'hFF : 8'h00, 1'b1, (k[0] && i == lens[k] - 1));
            if (!k[0]) send_word(8'h00, 1'b0, 1'b1);
        end
        drain();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 120) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            send_message(len, 1);
            sent += len + 1;
        end
        drain();
    endtask

    // Long receiver hold-off while messages keep coming; then no idling
    task automatic test_pressure();
        hold_cycles = 600;
        for (int m = 0; m < 4; m++) send_message($urandom_range(10), 0);
        drain();
        idle_pct = 0;
        for (int m = 0; m < 3; m++) send_message($urandom_range(40), 0);
        drain();
        idle_pct = 29;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data_byte = '0;
        i_has_byte = 1'b0;
        i_end_of_message = 1'b0;
        idle_pct = 29;
        hold_cycles = 0;
        hasher_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_boundaries();
        test_pressure();
        test_random();
        if (mismatches == 0 && digest_queue.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        wait (cycle_count > 1000000);
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/sha256_pkg.sv
sv/sha256_message_hasher_top.sv
sv/sha256_checker.sv
tb/sv/tb_sha256_message_hasher_top.sv
